// ===== hw/rtl/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX1,
        MODE_BSL,
        MODE_U,
        MODE_HEX2
    } jsu_mode_t;

    typedef enum logic [1:0] {
        JOB_RAW,
        JOB_CP,
        JOB_CLOSE,
        JOB_ERR
    } jsu_kind_t;

    typedef struct packed {
        jsu_kind_t   kind;
        logic [20:0] cp;
        logic [3:0]  err;
    } jsu_job_t;

    localparam logic [1:0] ST_DATA   = 2'd0;
    localparam logic [1:0] ST_CLOSED = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE   = 4'd1;
    localparam logic [3:0] ERR_CONTROL    = 4'd2;
    localparam logic [3:0] ERR_BAD_ESC    = 4'd3;
    localparam logic [3:0] ERR_BAD_HEX    = 4'd4;
    localparam logic [3:0] ERR_LONE_LOW   = 4'd5;
    localparam logic [3:0] ERR_NO_LOW_ESC = 4'd6;
    localparam logic [3:0] ERR_BAD_PAIR   = 4'd7;
    localparam logic [3:0] ERR_NULL       = 4'd8;
    localparam logic [3:0] ERR_UNTERM     = 4'd9;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
        if (c >= 8'h61 && c <= 8'h66) r = {1'b0, c[3:0] + 4'd9};
        if (c >= 8'h41 && c <= 8'h46) r = {1'b0, c[3:0] + 4'd9};
        return r;
    endfunction

    // index of the last utf-8 byte
    function automatic logic [1:0] utf8_last(input logic [20:0] cp);
        logic [1:0] r;
        if (cp < 21'h80) r = 2'd0;
        else if (cp < 21'h800) r = 2'd1;
        else if (cp < 21'h10000) r = 2'd2;
        else r = 2'd3;
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [7:0] r;
        case (utf8_last(cp))
            2'd0: r = {1'b0, cp[6:0]};
            2'd1: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2:
            begin
                case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    r = {5'b11110, cp[20:18]};
                    2'd1:    r = {2'b10, cp[17:12]};
                    2'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/jsu_stream_if.sv =====
`default_nettype none
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       at_end;

    modport source (output valid, output in_byte, output at_end, input ready);
    modport sink (input valid, input in_byte, input at_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic [3:0] error_code;
    logic       last_of_run;

    modport source (output valid, output out_byte, output status, output error_code,
                    output last_of_run, input ready);
    modport sink (input valid, input out_byte, input status, input error_code,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/json_string_unescape_utf8.sv =====
// path: a job from an accepted request is queued, then loaded into the output register
// throughput: one request per cycle while the queue has room; a \u escape ending a
//   code point holds the output for each utf-8 byte (up to four), absorbed by the queue
// reset: rst_n asynchronous active low; clears parser state, queue and output valid
`default_nettype none
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    jsu_in_if.sink    req,
    jsu_out_if.source res
);

    jsu_job_t job;
    jsu_job_t head_job;
    logic     push;
    logic     full;
    logic     pop;
    logic     head_valid;
    logic     accept;

    assign req.ready = !full;
    assign accept    = req.valid && !full;

    jsu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .c      (req.in_byte),
        .at_end (req.at_end),
        .job    (job),
        .push   (push)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .res        (res)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/jsu_front.sv =====
`default_nettype none
module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] c,
    input  wire logic       at_end,
    output jsu_job_t        job,
    output logic            push
);

    jsu_mode_t   mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  hs_reg, hs_next;
    logic        emit;
    logic [4:0]  d;
    logic [15:0] unit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            hs_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            hs_reg   <= hs_next;
        end
    end

    assign push = accept && emit;

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        hs_next   = hs_reg;
        emit      = 1'b0;
        job.kind  = JOB_ERR;
        job.cp    = '0;
        job.err   = ERR_NONE;
        d         = hex_of(c);
        unit      = {acc_reg[11:0], d[3:0]};

        case (mode_reg)
            MODE_STR:
            begin
                emit = 1'b1;
                if (at_end)
                begin
                    job.err   = ERR_UNTERM;
                    mode_next = MODE_IDLE;
                end
                else if (c == CH_QUOTE)
                begin
                    job.kind  = JOB_CLOSE;
                    mode_next = MODE_IDLE;
                end
                else if (c < 8'h20)
                begin
                    job.err   = ERR_CONTROL;
                    mode_next = MODE_IDLE;
                end
                else if (c == CH_BSL)
                begin
                    emit      = 1'b0;
                    mode_next = MODE_ESC;
                end
                else
                begin
                    job.kind = JOB_RAW;
                    job.cp   = {13'd0, c};
                end
            end
            MODE_ESC:
            begin
                emit      = 1'b1;
                mode_next = MODE_STR;
                job.kind  = JOB_RAW;
                if (at_end)
                begin
                    job.kind  = JOB_ERR;
                    job.err   = ERR_UNTERM;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: job.cp = {13'd0, c};
                        CH_B: job.cp = 21'h08;
                        CH_F: job.cp = 21'h0C;
                        CH_N: job.cp = 21'h0A;
                        CH_R: job.cp = 21'h0D;
                        CH_T: job.cp = 21'h09;
                        CH_U:
                        begin
                            emit      = 1'b0;
                            mode_next = MODE_HEX1;
                            acc_next  = '0;
                            cnt_next  = '0;
                        end
                        default:
                        begin
                            job.kind  = JOB_ERR;
                            job.err   = ERR_BAD_ESC;
                            mode_next = MODE_IDLE;
                        end
                    endcase
                end
            end
            MODE_HEX1, MODE_HEX2:
            begin
                if (at_end || d[4])
                begin
                    emit      = 1'b1;
                    job.err   = at_end ? ERR_UNTERM : ERR_BAD_HEX;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    acc_next = unit;
                    if (cnt_reg != 2'd3)
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                    else
                    begin
                        cnt_next = '0;
                        emit     = 1'b1;
                        if (mode_reg == MODE_HEX1)
                        begin
                            if (unit >= 16'hDC00 && unit <= 16'hDFFF)
                            begin
                                job.err   = ERR_LONE_LOW;
                                mode_next = MODE_IDLE;
                            end
                            else if (unit >= 16'hD800 && unit <= 16'hDBFF)
                            begin
                                emit      = 1'b0;
                                hs_next   = unit[9:0];
                                mode_next = MODE_BSL;
                            end
                            else if (unit == 16'd0)
                            begin
                                job.err   = ERR_NULL;
                                mode_next = MODE_IDLE;
                            end
                            else
                            begin
                                job.kind  = JOB_CP;
                                job.cp    = {5'd0, unit};
                                mode_next = MODE_STR;
                            end
                        end
                        else if (unit < 16'hDC00 || unit > 16'hDFFF)
                        begin
                            job.err   = ERR_BAD_PAIR;
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            job.kind  = JOB_CP;
                            job.cp    = 21'h10000 + {1'b0, hs_reg, unit[9:0]};
                            mode_next = MODE_STR;
                        end
                    end
                end
            end
            MODE_BSL:
            begin
                if (at_end || c != CH_BSL)
                begin
                    emit      = 1'b1;
                    job.err   = ERR_NO_LOW_ESC;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    mode_next = MODE_U;
                end
            end
            MODE_U:
            begin
                if (at_end || c != CH_U)
                begin
                    emit      = 1'b1;
                    job.err   = ERR_NO_LOW_ESC;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    mode_next = MODE_HEX2;
                    acc_next  = '0;
                    cnt_next  = '0;
                end
            end
            default:
            begin
                if (!at_end && c == CH_QUOTE)
                begin
                    mode_next = MODE_STR;
                end
                else
                begin
                    emit      = 1'b1;
                    job.err   = ERR_NO_QUOTE;
                    mode_next = MODE_IDLE;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/jsu_queue.sv =====
`default_nettype none
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  jsu_job_t  push_job,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output jsu_job_t  head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_job_t        slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/jsu_back.sv =====
`default_nettype none
module jsu_back
    import jsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  head_valid,
    input  jsu_job_t   head_job,
    output logic       pop,
    jsu_out_if.source  res
);

    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [7:0] byte_reg;
    logic [1:0] status_reg;
    logic [3:0] code_reg;
    logic       last_reg;
    logic       load;
    logic [1:0] last_idx;
    logic       is_last;
    logic [7:0] byte_next;
    logic [1:0] status_next;
    logic [3:0] code_next;

    assign load     = head_valid && (!valid_reg || res.ready);
    assign last_idx = (head_job.kind == JOB_CP) ? utf8_last(head_job.cp) : 2'd0;
    assign is_last  = (idx_reg == last_idx);
    assign pop      = load && is_last;

    always_comb
    begin
        byte_next   = '0;
        status_next = ST_DATA;
        code_next   = ERR_NONE;
        case (head_job.kind)
            JOB_RAW:   byte_next = head_job.cp[7:0];
            JOB_CP:    byte_next = utf8_byte(head_job.cp, idx_reg);
            JOB_CLOSE: status_next = ST_CLOSED;
            default:
            begin
                status_next = ST_ERROR;
                code_next   = head_job.err;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (res.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            status_reg <= status_next;
            code_reg   <= code_next;
            last_reg   <= is_last;
        end
    end

    assign res.valid       = valid_reg;
    assign res.out_byte    = byte_reg;
    assign res.status      = status_reg;
    assign res.error_code  = code_reg;
    assign res.last_of_run = last_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/jsu_checker.sv =====
`default_nettype none
module jsu_checker
    import jsu_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       valid,
    input wire logic       ready,
    input wire logic [7:0] out_byte,
    input wire logic [1:0] status,
    input wire logic [3:0] error_code,
    input wire logic       last_of_run
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped while stalled");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == ST_ERROR |->
            last_of_run && out_byte == 8'd0 && error_code != ERR_NONE)
        else $error("malformed error result");

    a_close_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == ST_CLOSED |->
            last_of_run && out_byte == 8'd0 && error_code == ERR_NONE)
        else $error("malformed close result");

    a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != ST_ERROR |->
            error_code == ERR_NONE && (status == ST_DATA || status == ST_CLOSED))
        else $error("bad status or stray error code");

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (res.valid),
    .ready       (res.ready),
    .out_byte    (res.out_byte),
    .status      (res.status),
    .error_code  (res.error_code),
    .last_of_run (res.last_of_run)
);
`default_nettype wire

// ===== dv/json_string_unescape_utf8_test.sv =====
`default_nettype none
module json_string_unescape_utf8_test;
    import jsu_pkg::*;

    localparam int RANDOM_ITEMS = 130;
    localparam int CALM_TAIL    = 40;
    localparam int LIMIT        = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       at_end;
    } text_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic [3:0] code;
        logic       last;
    } decoded_t;

    logic clk;
    logic rst_n;

    jsu_in_if  req_ch ();
    jsu_out_if res_ch ();

    json_string_unescape_utf8 i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    text_req_t text_q[$];
    decoded_t  decoded_q[$];
    decoded_t  burst[$];

    // predictor state
    jsu_mode_t   mode;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [9:0]  high_bits;

    int src_gap;
    int sink_gap;
    int n_requests;
    int n_checked;
    int n_closed;
    int n_errors;
    int n_mismatch;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h10;
        if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
        if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
        return v[4:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        logic [7:0] c;
        if (v < 4'd10) c = 8'h30 + v;
        else if (upper) c = 8'h37 + v;
        else c = 8'h57 + v;
        return c;
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        return c == CH_QUOTE || c == CH_BSL || c == CH_SLASH || c == CH_B || c == CH_F ||
               c == CH_N || c == CH_R || c == CH_T || c == CH_U;
    endfunction

    function void add_result(input logic [7:0] d, input logic [1:0] s, input logic [3:0] e);
        burst.push_back({d, s, e, 1'b0});
    endfunction

    function void raise_error(input logic [3:0] e);
        mode = MODE_IDLE;
        add_result(8'h00, ST_ERROR, e);
    endfunction

    function void emit_code_point(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            add_result({1'b0, cp[6:0]}, ST_DATA, ERR_NONE);
        end
        else if (cp < 21'h800)
        begin
            add_result({3'b110, cp[10:6]}, ST_DATA, ERR_NONE);
            add_result({2'b10, cp[5:0]}, ST_DATA, ERR_NONE);
        end
        else if (cp < 21'h10000)
        begin
            add_result({4'b1110, cp[15:12]}, ST_DATA, ERR_NONE);
            add_result({2'b10, cp[11:6]}, ST_DATA, ERR_NONE);
            add_result({2'b10, cp[5:0]}, ST_DATA, ERR_NONE);
        end
        else
        begin
            add_result({5'b11110, cp[20:18]}, ST_DATA, ERR_NONE);
            add_result({2'b10, cp[17:12]}, ST_DATA, ERR_NONE);
            add_result({2'b10, cp[11:6]}, ST_DATA, ERR_NONE);
            add_result({2'b10, cp[5:0]}, ST_DATA, ERR_NONE);
        end
        mode = MODE_STR;
    endfunction

    task automatic unescape_byte(input logic [7:0] c, input logic e);
        logic [4:0]  d;
        logic [15:0] unit;
        burst.delete();
        case (mode)
            MODE_STR:
            begin
                if (e) raise_error(ERR_UNTERM);
                else if (c == CH_QUOTE)
                begin
                    mode = MODE_IDLE;
                    add_result(8'h00, ST_CLOSED, ERR_NONE);
                end
                else if (c < 8'h20) raise_error(ERR_CONTROL);
                else if (c == CH_BSL) mode = MODE_ESC;
                else add_result(c, ST_DATA, ERR_NONE);
            end
            MODE_ESC:
            begin
                if (e) raise_error(ERR_UNTERM);
                else
                begin
                    mode = MODE_STR;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: add_result(c, ST_DATA, ERR_NONE);
                        CH_B: add_result(8'h08, ST_DATA, ERR_NONE);
                        CH_F: add_result(8'h0C, ST_DATA, ERR_NONE);
                        CH_N: add_result(8'h0A, ST_DATA, ERR_NONE);
                        CH_R: add_result(8'h0D, ST_DATA, ERR_NONE);
                        CH_T: add_result(8'h09, ST_DATA, ERR_NONE);
                        CH_U:
                        begin
                            mode = MODE_HEX1;
                            hex_acc = 16'h0000;
                            hex_cnt = 2'd0;
                        end
                        default: raise_error(ERR_BAD_ESC);
                    endcase
                end
            end
            MODE_HEX1, MODE_HEX2:
            begin
                d = hex_value(c);
                if (e) raise_error(ERR_UNTERM);
                else if (d[4]) raise_error(ERR_BAD_HEX);
                else
                begin
                    hex_acc = {hex_acc[11:0], d[3:0]};
                    if (hex_cnt < 2'd3) hex_cnt = hex_cnt + 2'd1;
                    else
                    begin
                        hex_cnt = 2'd0;
                        unit = hex_acc;
                        if (mode == MODE_HEX1)
                        begin
                            if (unit >= 16'hDC00 && unit <= 16'hDFFF) raise_error(ERR_LONE_LOW);
                            else if (unit >= 16'hD800 && unit <= 16'hDBFF)
                            begin
                                high_bits = unit[9:0];
                                mode = MODE_BSL;
                            end
                            else if (unit == 16'h0000) raise_error(ERR_NULL);
                            else emit_code_point({5'b0, unit});
                        end
                        else if (unit < 16'hDC00 || unit > 16'hDFFF) raise_error(ERR_BAD_PAIR);
                        else emit_code_point(21'h10000 + {1'b0, high_bits, unit[9:0]});
                    end
                end
            end
            MODE_BSL:
            begin
                if (e || c != CH_BSL) raise_error(ERR_NO_LOW_ESC);
                else mode = MODE_U;
            end
            MODE_U:
            begin
                if (e || c != CH_U) raise_error(ERR_NO_LOW_ESC);
                else
                begin
                    mode = MODE_HEX2;
                    hex_acc = 16'h0000;
                    hex_cnt = 2'd0;
                end
            end
            default:
            begin
                if (!e && c == CH_QUOTE) mode = MODE_STR;
                else raise_error(ERR_NO_QUOTE);
            end
        endcase
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) decoded_q.push_back(burst[i]);
    endtask

    // stimulus helpers
    task automatic push_byte(input logic [7:0] b);
        text_q.push_back({b, 1'b0});
    endtask

    task automatic push_end();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        text_q.push_back({b, 1'b1});
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_unit(input logic [15:0] u);
        push_byte(CH_BSL);
        push_byte(CH_U);
        for (int i = 3; i >= 0; i--)
            push_byte(hex_char(u[i*4 +: 4], 1'($urandom_range(0, 1))));
    endtask

    task automatic push_plain();
        logic [7:0] b;
        b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BSL) b = 8'($urandom_range(8'h20, 8'hFF));
        push_byte(b);
    endtask

    function automatic logic [15:0] rand_bmp();
        logic [15:0] u;
        case ($urandom_range(0, 2))
            0: u = 16'($urandom_range(16'h0001, 16'h007F));
            1: u = 16'($urandom_range(16'h0080, 16'h07FF));
            default:
            begin
                if ($urandom_range(0, 1)) u = 16'($urandom_range(16'h0800, 16'hD7FF));
                else u = 16'($urandom_range(16'hE000, 16'hFFFF));
            end
        endcase
        return u;
    endfunction

    task automatic push_segment();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4) push_plain();
        else if (k < 6)
        begin
            push_byte(CH_BSL);
            case ($urandom_range(0, 7))
                0: push_byte(CH_QUOTE);
                1: push_byte(CH_BSL);
                2: push_byte(CH_SLASH);
                3: push_byte(CH_B);
                4: push_byte(CH_F);
                5: push_byte(CH_N);
                6: push_byte(CH_R);
                default: push_byte(CH_T);
            endcase
        end
        else if (k < 8) push_unit(rand_bmp());
        else
        begin
            push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
            push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
    endtask

    task automatic push_fault();
        logic [7:0]  b;
        logic [15:0] u;
        int          n;
        case ($urandom_range(0, 8))
            0: push_byte(8'($urandom_range(0, 31)));
            1:
            begin
                b = 8'($urandom_range(0, 255));
                while (is_escape_letter(b)) b = 8'($urandom_range(0, 255));
                push_byte(CH_BSL);
                push_byte(b);
            end
            2:
            begin
                n = $urandom_range(0, 3);
                push_byte(CH_BSL);
                push_byte(CH_U);
                for (int i = 0; i < n; i++)
                    push_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
                b = 8'($urandom_range(0, 255));
                while (hex_value(b) < 5'h10) b = 8'($urandom_range(0, 255));
                push_byte(b);
            end
            3: push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
            4:
            begin
                push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                if ($urandom_range(0, 3) == 0) push_end();
                else
                begin
                    b = 8'($urandom_range(0, 255));
                    while (b == CH_BSL) b = 8'($urandom_range(0, 255));
                    push_byte(b);
                end
            end
            5:
            begin
                push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                push_byte(CH_BSL);
                if ($urandom_range(0, 3) == 0) push_end();
                else
                begin
                    b = 8'($urandom_range(0, 255));
                    while (b == CH_U) b = 8'($urandom_range(0, 255));
                    push_byte(b);
                end
            end
            6:
            begin
                push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                if ($urandom_range(0, 1)) u = 16'($urandom_range(16'h0000, 16'hDBFF));
                else u = 16'($urandom_range(16'hE000, 16'hFFFF));
                push_unit(u);
            end
            7: push_unit(16'h0000);
            default:
            begin
                case ($urandom_range(0, 2))
                    0: ;
                    1: push_byte(CH_BSL);
                    default:
                    begin
                        n = $urandom_range(0, 3);
                        push_byte(CH_BSL);
                        push_byte(CH_U);
                        for (int i = 0; i < n; i++)
                            push_byte(hex_char(4'($urandom_range(0, 15)), 1'b1));
                    end
                endcase
                push_end();
            end
        endcase
    endtask

    task automatic push_string();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 3) == 0) push_end();
                else push_byte(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            push_byte(CH_QUOTE);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) push_segment();
            if (r < 78) push_byte(CH_QUOTE);
            else push_fault();
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.in_byte <= 8'h00;
            req_ch.at_end  <= 1'b0;
            src_gap = 0;
        end
        else if (!(req_ch.valid && !req_ch.ready))
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                unescape_byte(req_ch.in_byte, req_ch.at_end);
                void'(text_q.pop_front());
                n_requests++;
            end
            nv = 1'b0;
            if (src_gap > 0) src_gap--;
            else if (text_q.size() == 0) nv = 1'b0;
            else if (text_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                src_gap = $urandom_range(1, 15) - 1;
            else nv = 1'b1;
            req_ch.valid <= nv;
            if (nv)
            begin
                req_ch.in_byte <= text_q[0].data;
                req_ch.at_end  <= text_q[0].at_end;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        decoded_t exp_r;
        logic     rdy;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                n_checked++;
                if (res_ch.status == ST_CLOSED) n_closed++;
                if (res_ch.status == ST_ERROR) n_errors++;
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result: out_byte %h status %0d error_code %0d",
                           res_ch.out_byte, res_ch.status, res_ch.error_code);
                    n_mismatch++;
                end
                else
                begin
                    exp_r = decoded_q.pop_front();
                    if (res_ch.out_byte !== exp_r.data)
                    begin
                        $error("out_byte: expected %h, actual %h", exp_r.data, res_ch.out_byte);
                        n_mismatch++;
                    end
                    if (res_ch.status !== exp_r.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_r.status, res_ch.status);
                        n_mismatch++;
                    end
                    if (res_ch.error_code !== exp_r.code)
                    begin
                        $error("error_code: expected %0d, actual %0d",
                               exp_r.code, res_ch.error_code);
                        n_mismatch++;
                    end
                    if (res_ch.last_of_run !== exp_r.last)
                    begin
                        $error("last_of_run: expected %0d, actual %0d",
                               exp_r.last, res_ch.last_of_run);
                        n_mismatch++;
                    end
                end
            end
            rdy = 1'b0;
            if (sink_gap > 0) sink_gap--;
            else if (text_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
                sink_gap = $urandom_range(1, 15) - 1;
            else rdy = 1'b1;
            res_ch.ready <= rdy;
        end
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int target;
        rst_n = 1'b0;
        mode = MODE_IDLE;
        hex_acc = 16'h0000;
        hex_cnt = 2'd0;
        high_bits = 10'h000;
        n_requests = 0;
        n_checked = 0;
        n_closed = 0;
        n_errors = 0;
        n_mismatch = 0;

        // no opening quote, by byte and by end of text
        push_byte(8'h41);
        push_end();
        // plain byte extremes
        push_byte(CH_QUOTE);
        push_byte(8'h20);
        push_byte(8'h7F);
        push_byte(8'h80);
        push_byte(8'hFF);
        push_byte(CH_QUOTE);
        // every simple escape
        push_str("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
        // utf-8 length boundaries, both hex cases, surrogate pair extremes
        push_str("\"\\u0041\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\uabcd");
        push_str("\\uD800\\uDC00\\udbff\\udfff\"");
        // errors
        push_byte(CH_QUOTE);
        push_byte(8'h00);
        push_byte(CH_QUOTE);
        push_byte(8'h1F);
        push_str("\"\\x");
        push_str("\"\\u1g");
        push_str("\"\\uDC00");
        push_str("\"\\uDFFF");
        push_str("\"\\uD800a");
        push_str("\"\\uD800\\x");
        push_str("\"\\uD800");
        push_end();
        push_str("\"\\uDBFF\\");
        push_end();
        push_str("\"\\uD800\\u0041");
        push_str("\"\\uD800\\uE000");
        push_str("\"\\u0000");
        push_byte(CH_QUOTE);
        push_end();
        push_str("\"\\");
        push_end();
        push_str("\"\\u12");
        push_end();

        target = text_q.size() + RANDOM_ITEMS;
        while (text_q.size() < target) push_string();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (text_q.size() != 0 || req_ch.valid) @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d requests: plain bytes, all escapes, 1 to 4 byte utf-8, all errors",
                 n_requests);
        $display("checked %0d results, %0d closed strings, %0d errors, %0d mismatches",
                 n_checked, n_closed, n_errors, n_mismatch);
        if (n_mismatch == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ===== json_string_unescape_utf8.f =====
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_stream_if.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape_utf8.sv
hw/rtl/jsu_checker.sv
dv/json_string_unescape_utf8_test.sv
